### rtl/core/fbf_pkg.sv
// Shared types, constants and the descriptor byte function of the firmware block framer.
package fbf_pkg;

    // Fixed frame layout.
    localparam int DESC_BYTES    = 20;
    localparam int TRAILER_BYTES = 4;
    localparam int EXTRA_BYTES   = 4;
    localparam int DESC_LEN_OFS  = 8;
    localparam int DESC_SUM_OFS  = 18;
    localparam int DESC_LAST_BIT = 10;
    localparam int DESC_FIRST_BIT = 11;
    localparam int DESC_SEL_BIT  = 12;
    localparam int DESC_SEQ_BIT  = 18;

    // Result grouping and the result queue.
    localparam int MAX_RUN     = 29;
    localparam int QUEUE_DEPTH = 64;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
    localparam int RUN_W       = $clog2(MAX_RUN + 1);

    // Field and counter widths.
    localparam int LEN_W    = 21;
    localparam int PAD_W    = LEN_W + 1;
    localparam int DIDX_W   = $clog2(DESC_BYTES);
    localparam int TIDX_W   = $clog2(TRAILER_BYTES);
    localparam int ENTRY_W  = 9;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IMAGE_LENGTH = 2'd0;
    localparam logic [1:0] CFG_IMAGE_SELECT = 2'd1;
    localparam logic [1:0] CFG_FRAME_TYPE   = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0] image_length;
        logic             image_select;
        logic [1:0]       frame_type_code;
    } cfg_t;

    // One result entry toward the queue memory.
    typedef struct packed {
        logic       wr;
        logic [7:0] data;
        logic       fend;
    } push_t;

    // End of one input beat's work: how many entries the beat releases.
    typedef struct packed {
        logic             valid;
        logic [RUN_W-1:0] size;
    } commit_t;

    // Room available on the queue side.
    typedef struct packed {
        logic room;
        logic chunk_room;
    } sink_t;

    function automatic logic [7:0] desc_byte(
        input logic [DIDX_W-1:0] idx,
        input logic [1:0]        frame_type,
        input logic              last,
        input logic              first,
        input logic              sel,
        input logic [15:0]       len
    );
        logic [31:0]             w0;
        logic [15:0]             hsum;
        logic [DESC_BYTES*8-1:0] d;
        w0 = '0;
        w0[1:0] = frame_type;
        w0[DESC_LAST_BIT] = last;
        w0[DESC_FIRST_BIT] = first;
        w0[DESC_SEL_BIT] = sel;
        w0[DESC_SEQ_BIT] = 1'b1;
        // Only halfwords 0, 1 and 4 can be nonzero.
        hsum = w0[15:0] ^ w0[31:16] ^ len;
        d = '0;
        d[31:0] = w0;
        d[DESC_LEN_OFS*8 +: 16] = len;
        d[DESC_SUM_OFS*8 +: 16] = hsum;
        return d[idx*8 +: 8];
    endfunction

endpackage

### rtl/core/fbf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fbf_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### rtl/core/fbf_framer.sv
// Frame sequencer: builds descriptor, payload, padding and trailer entries one per cycle while the queue side has room.
module fbf_framer #(
    parameter int BLOCK_PAYLOAD = 488
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fbf_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        image_byte,
    input  fbf_pkg::sink_t    sink,
    output fbf_pkg::push_t    push,
    output fbf_pkg::commit_t  commit
);
    import fbf_pkg::*;

    localparam int BOW = $clog2(BLOCK_PAYLOAD + 1);
    localparam logic [BOW-1:0]   BP_B = BOW'(BLOCK_PAYLOAD);
    localparam logic [PAD_W-1:0] BP_P = PAD_W'(BLOCK_PAYLOAD);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ITEM  = 2'd1;
    localparam logic [1:0] ST_DESC  = 2'd2;
    localparam logic [1:0] ST_TRAIL = 2'd3;

    localparam logic [DIDX_W-1:0] DESC_LAST  = DIDX_W'(DESC_BYTES - 1);
    localparam logic [TIDX_W-1:0] TRAIL_LAST = TIDX_W'(TRAILER_BYTES - 1);
    localparam logic [QCNT_W-1:0] Q_FULL     = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QCNT_W-1:0] RUN_MAX_Q  = QCNT_W'(MAX_RUN);

    logic [1:0]        state_reg, state_next;
    logic [7:0]        cur_byte_reg, cur_byte_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [PAD_W-1:0]  pad_left_reg, pad_left_next;
    logic [BOW-1:0]    block_offset_reg, block_offset_next;
    logic              first_reg, first_next;
    logic              desc_done_reg, desc_done_next;
    logic              extra_done_reg, extra_done_next;
    logic [15:0]       cksum_reg, cksum_next;
    logic              parity_reg, parity_next;
    logic [DIDX_W-1:0] desc_idx_reg, desc_idx_next;
    logic [TIDX_W-1:0] trail_idx_reg, trail_idx_next;
    logic [QCNT_W-1:0] lq_reg, lq_next;

    logic              finishing;
    logic              go;
    logic              accept;
    logic              lq_full;
    logic              kept;
    logic [QCNT_W-1:0] lq_after;
    logic [RUN_W-1:0]  run_n;
    logic [PAD_W-1:0]  pad_eff;
    logic              desc_last;
    logic [15:0]       desc_len;
    logic [DIDX_W-1:0] desc_sel;
    logic [7:0]        desc_data;
    logic [7:0]        trail_data;
    logic              desc_needed;
    logic [PAD_W-1:0]  pad_dec;
    logic [BOW-1:0]    bo_inc;
    logic [7:0]        step_data;
    logic              step_fend;
    logic [LEN_W-1:0]  img_len;
    logic [PAD_W-1:0]  img_pad;

    // The extra block is folded in once, at the descriptor of the block that would
    // otherwise end exactly on the image end.
    assign pad_eff = (pad_left_reg == BP_P && !extra_done_reg) ?
                     pad_left_reg + PAD_W'(EXTRA_BYTES) : pad_left_reg;
    assign desc_last = (pad_eff <= BP_P);
    assign desc_len  = desc_last ? 16'(pad_eff + PAD_W'(TRAILER_BYTES)) : 16'(BLOCK_PAYLOAD);
    assign desc_sel  = (state_reg == ST_DESC) ? desc_idx_reg : '0;
    assign desc_data = desc_byte(desc_sel, cfg.frame_type_code, desc_last, first_reg,
                                 cfg.image_select, desc_len);
    assign trail_data = (trail_idx_reg == TIDX_W'(0)) ? cksum_reg[7:0] :
                        (trail_idx_reg == TIDX_W'(1)) ? cksum_reg[15:8] : 8'h00;
    assign desc_needed = (block_offset_reg == '0) && !desc_done_reg;
    assign pad_dec = pad_left_reg - PAD_W'(1);
    assign bo_inc  = block_offset_reg + BOW'(1);

    always_comb
    begin
        finishing = 1'b0;
        step_data = 8'h00;
        step_fend = 1'b0;
        case (state_reg)
            ST_ITEM:
            begin
                if (desc_needed)
                begin
                    step_data = desc_data;
                end
                else
                begin
                    step_data = cur_byte_reg;
                    if (pad_dec != '0)
                    begin
                        step_fend = (bo_inc == BP_B);
                        finishing = (bytes_left_reg != '0);
                    end
                end
            end
            ST_DESC:
            begin
                step_data = desc_data;
            end
            ST_TRAIL:
            begin
                step_data = trail_data;
                step_fend = (trail_idx_reg == TRAIL_LAST);
                finishing = (trail_idx_reg == TRAIL_LAST);
            end
            default:
            begin
                step_data = 8'h00;
            end
        endcase
    end

    assign lq_full  = (lq_reg == Q_FULL);
    assign go       = (state_reg != ST_IDLE) && (lq_full || sink.room) &&
                      (!finishing || sink.chunk_room);
    assign kept     = go && !lq_full;
    assign lq_after = lq_reg + QCNT_W'(kept);
    assign run_n    = (lq_after >= RUN_MAX_Q) ? RUN_W'(MAX_RUN) : lq_after[RUN_W-1:0];
    assign in_ready = (state_reg == ST_IDLE) || (finishing && go);
    assign accept   = in_valid && in_ready;

    assign push.wr   = kept;
    assign push.data = step_data;
    assign push.fend = step_fend;
    assign commit.valid = go && finishing;
    assign commit.size  = run_n;

    assign img_len = (cfg.image_length == '0) ? LEN_W'(1) : cfg.image_length;
    assign img_pad = ({1'b0, img_len} + PAD_W'(3)) & ~PAD_W'(3);

    always_comb
    begin
        state_next        = state_reg;
        cur_byte_next     = cur_byte_reg;
        bytes_left_next   = bytes_left_reg;
        pad_left_next     = pad_left_reg;
        block_offset_next = block_offset_reg;
        first_next        = first_reg;
        desc_done_next    = desc_done_reg;
        extra_done_next   = extra_done_reg;
        cksum_next        = cksum_reg;
        parity_next       = parity_reg;
        desc_idx_next     = desc_idx_reg;
        trail_idx_next    = trail_idx_reg;
        lq_next           = commit.valid ? lq_after - QCNT_W'(run_n) : lq_after;

        if (go)
        begin
            case (state_reg)
                ST_ITEM:
                begin
                    if (desc_needed)
                    begin
                        desc_idx_next = DIDX_W'(1);
                        state_next = ST_DESC;
                    end
                    else
                    begin
                        pad_left_next = pad_dec;
                        desc_done_next = 1'b0;
                        if (pad_dec == '0)
                        begin
                            block_offset_next = '0;
                            trail_idx_next = '0;
                            state_next = ST_TRAIL;
                        end
                        else
                        begin
                            block_offset_next = (bo_inc == BP_B) ? '0 : bo_inc;
                            if (bytes_left_reg == '0)
                            begin
                                // Image bytes are used up: the rest is zero padding.
                                cur_byte_next = 8'h00;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
                ST_DESC:
                begin
                    if (desc_idx_reg == DESC_LAST)
                    begin
                        extra_done_next = extra_done_reg || (pad_eff != pad_left_reg);
                        pad_left_next = pad_eff;
                        first_next = 1'b0;
                        desc_done_next = 1'b1;
                        state_next = ST_ITEM;
                    end
                    else
                    begin
                        desc_idx_next = desc_idx_reg + DIDX_W'(1);
                    end
                end
                ST_TRAIL:
                begin
                    if (trail_idx_reg == TRAIL_LAST)
                    begin
                        first_next = 1'b1;
                        block_offset_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        trail_idx_next = trail_idx_reg + TIDX_W'(1);
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        if (accept)
        begin
            state_next = ST_ITEM;
            cur_byte_next = image_byte;
            if (bytes_left_reg == '0)
            begin
                // A new image starts with this byte.
                bytes_left_next = img_len - LEN_W'(1);
                pad_left_next = img_pad;
                block_offset_next = '0;
                first_next = 1'b1;
                desc_done_next = 1'b0;
                extra_done_next = 1'b0;
                cksum_next = {8'h00, image_byte};
                parity_next = 1'b1;
            end
            else
            begin
                bytes_left_next = bytes_left_reg - LEN_W'(1);
                cksum_next = cksum_reg ^ (parity_reg ? {image_byte, 8'h00} :
                                                       {8'h00, image_byte});
                parity_next = !parity_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            bytes_left_reg   <= '0;
            pad_left_reg     <= '0;
            block_offset_reg <= '0;
            first_reg        <= 1'b1;
            desc_done_reg    <= 1'b0;
            extra_done_reg   <= 1'b0;
            cksum_reg        <= '0;
            parity_reg       <= 1'b0;
            desc_idx_reg     <= '0;
            trail_idx_reg    <= '0;
            lq_reg           <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            bytes_left_reg   <= bytes_left_next;
            pad_left_reg     <= pad_left_next;
            block_offset_reg <= block_offset_next;
            first_reg        <= first_next;
            desc_done_reg    <= desc_done_next;
            extra_done_reg   <= extra_done_next;
            cksum_reg        <= cksum_next;
            parity_reg       <= parity_next;
            desc_idx_reg     <= desc_idx_next;
            trail_idx_reg    <= trail_idx_next;
            lq_reg           <= lq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_byte_reg <= cur_byte_next;
    end
endmodule

### rtl/core/firmware_block_framer_top.sv
// Top level of the firmware block framer: configuration, frame sequencer, result queue.
//
// The framer takes one firmware byte per input beat and sends the download frame
// stream as output beats: each frame is a 20-byte descriptor and up to
// BLOCK_PAYLOAD payload bytes. The image is followed by zero padding to a
// four-byte boundary, an extra four-byte block when the padded size is an
// exact multiple of BLOCK_PAYLOAD, and a four-byte halfword-XOR trailer.
// Image bytes in the middle of a block are accepted back to back while the
// queue has room. The byte that opens a block holds the input while its
// descriptor goes out, and the last byte of an image holds it while the
// padding, any extra block and the trailer go out. This pacing comes from
// the single write port of the 64-entry result queue, which takes at most
// one entry per cycle; the output side drains it at one beat per cycle
// while out_ready is high and a run is released. The results of one input beat
// form a run of at most 29 beats, the last one marked with run_end; results
// beyond 29 stay queued and open the run of the next input beat. image_length
// is sampled when an image starts, image_select and frame_type_code whenever
// a descriptor is built. Configuration registers are written through cfg_we,
// cfg_index and cfg_data and should only change while no work is pending.
module firmware_block_framer_top #(
    parameter int BLOCK_PAYLOAD = 488
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [20:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  image_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        frame_end,
    output logic        run_end
);
    import fbf_pkg::*;

    localparam logic [QCNT_W-1:0] Q_FULL = QCNT_W'(QUEUE_DEPTH);

    cfg_t    cfg_reg;
    push_t   push;
    commit_t commit;
    sink_t   sink;

    // Queue memory pointers and the count of entries written but not yet read.
    logic [QADDR_W-1:0] wr_ptr_reg;
    logic [QADDR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0]  phys_cnt_reg;

    // Run sizes waiting for the output side, head in slot 0.
    logic [RUN_W-1:0]   pend0_reg, pend0_next;
    logic [RUN_W-1:0]   pend1_reg, pend1_next;
    logic [1:0]         pend_cnt_reg, pend_cnt_next;
    logic [RUN_W-1:0]   rd_left_reg;
    logic               out_valid_reg;
    logic               run_end_reg;

    logic               avail;
    logic               issue;
    logic               pop;
    logic [RUN_W-1:0]   eff_left;
    logic [ENTRY_W-1:0] rd_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_length    <= LEN_W'(1);
            cfg_reg.image_select    <= 1'b0;
            cfg_reg.frame_type_code <= 2'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_LENGTH: cfg_reg.image_length <= cfg_data;
                CFG_IMAGE_SELECT: cfg_reg.image_select <= cfg_data[0];
                CFG_FRAME_TYPE:   cfg_reg.frame_type_code <= cfg_data[1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The sequencer may only add an entry when the memory has a free slot, and
    // only close a beat's work when the run size list has a free slot.
    assign sink.room       = (phys_cnt_reg < Q_FULL);
    assign sink.chunk_room = (pend_cnt_reg < 2'd2);

    fbf_framer #(
        .BLOCK_PAYLOAD(BLOCK_PAYLOAD)
    ) u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .image_byte (image_byte),
        .sink       (sink),
        .push       (push),
        .commit     (commit)
    );

    fbf_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (push.wr),
        .wr_addr (wr_ptr_reg),
        .wr_data ({push.fend, push.data}),
        .rd_en   (issue),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    // A read is issued only for entries inside a released run, and only when the
    // output register is empty or its beat is taken in this cycle.
    assign avail    = (rd_left_reg != '0) || (pend_cnt_reg != 2'd0);
    assign issue    = avail && (!out_valid_reg || out_ready);
    assign pop      = issue && (rd_left_reg == '0);
    assign eff_left = (rd_left_reg != '0) ? rd_left_reg : pend0_reg;

    always_comb
    begin
        pend0_next    = pend0_reg;
        pend1_next    = pend1_reg;
        pend_cnt_next = pend_cnt_reg;
        if (pop && commit.valid)
        begin
            pend0_next = (pend_cnt_reg == 2'd2) ? pend1_reg : commit.size;
            pend1_next = commit.size;
        end
        else if (pop)
        begin
            pend0_next = pend1_reg;
            pend_cnt_next = pend_cnt_reg - 2'd1;
        end
        else if (commit.valid)
        begin
            if (pend_cnt_reg == 2'd0)
            begin
                pend0_next = commit.size;
            end
            else
            begin
                pend1_next = commit.size;
            end
            pend_cnt_next = pend_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            phys_cnt_reg  <= '0;
            pend_cnt_reg  <= '0;
            rd_left_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (push.wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + QADDR_W'(1);
            end
            if (issue)
            begin
                rd_ptr_reg  <= rd_ptr_reg + QADDR_W'(1);
                rd_left_reg <= eff_left - RUN_W'(1);
            end
            phys_cnt_reg  <= phys_cnt_reg + QCNT_W'(push.wr) - QCNT_W'(issue);
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= issue || (out_valid_reg && !out_ready);
        end
    end

    // Payload registers hold while the output beat waits.
    always_ff @(posedge clk)
    begin
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
        if (issue)
        begin
            run_end_reg <= (eff_left == RUN_W'(1));
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = rd_data[7:0];
    assign frame_end  = rd_data[8];
    assign run_end    = run_end_reg;
endmodule

### rtl/core/fbf_checker.sv
// Port-level checker for the firmware block framer and its bind to the top level.
module fbf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  image_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  frame_byte,
    input logic        frame_end,
    input logic        run_end
);
    // Coming out of reset the block holds no result and takes a first beat at once.
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result beat shown right after reset");

    a_reset_ready: assert property (@(posedge clk) $rose(rst_n) |-> in_ready)
        else $error("input not ready right after reset");

    // An offered input beat stays offered with the same byte until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(image_byte))
        else $error("input beat withdrawn or changed before it was taken");

    // A result beat that waits stays offered with the same contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat withdrawn before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(frame_byte) && $stable(frame_end) && $stable(run_end))
        else $error("result beat changed while waiting");
endmodule

bind firmware_block_framer_top fbf_checker u_fbf_checker (.*);

### tb/firmware_block_framer_top_tb.sv
// Self-checking testbench for the firmware block framer: directed table, random images, scoreboard.
`timescale 1ns / 100ps

module firmware_block_framer_top_tb;

    import fbf_pkg::*;

    // The block runs with its standard payload size. The frame model below
    // uses the same value to decide where blocks end and when the extra
    // four-byte block is added.
    localparam int BLOCK_PAYLOAD = 488;

    // Idle cycles granted after the last expected beat before a register
    // write. This covers queue writes of an image's tail that are still in
    // flight when the released run has already drained.
    localparam int SETTLE_CYCLES = 48;
    localparam int END_CYCLES    = 64;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_REPORTS   = 10;
    localparam int DIR_ROWS      = 28;

    // One output beat: frame byte, end of frame, end of the run of one input.
    typedef struct packed {
        logic [7:0] data;
        logic       fend;
        logic       rend;
    } frame_beat_t;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    // One row of the directed table. Register rows carry an index and a
    // value; byte rows carry the image byte in the low bits of val. Pinned
    // rows also carry the run length and the running image checksum that
    // the byte must produce.
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [20:0] val;
        logic        pinned;
        logic [5:0]  run_len;
        logic [15:0] sum;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [20:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  image_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic        run_end;

    firmware_block_framer_top #(
        .BLOCK_PAYLOAD (BLOCK_PAYLOAD)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .image_byte (image_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .run_end    (run_end)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Frame model. It keeps its own copy of the registers and of the image
    // and block counters. Beats made by one input byte go to a backlog that
    // mirrors the block's 64-entry result queue; at most MAX_RUN of them are
    // released per input byte into frame_expect, and whatever is left opens
    // the run of the next byte.
    // ------------------------------------------------------------------
    logic [20:0] len_reg = 21'd1;
    logic        sel_reg = 1'b0;
    logic [1:0]  type_reg = 2'd0;

    int          blk_ofs = 0;
    int          bytes_left = 0;
    int          pad_left = 0;
    logic        first_pend = 1'b1;
    logic [15:0] csum = '0;
    logic        parity = 1'b0;
    int          last_run_len = 0;

    frame_beat_t frame_backlog[$];
    frame_beat_t frame_expect[$];

    int          mismatches = 0;
    int          cycle_count = 0;
    int          burst_left = 0;

    // A full backlog drops new beats, as the block's queue does.
    task automatic queue_byte(input logic [7:0] d, input logic fe);
        if (frame_backlog.size() < QUEUE_DEPTH)
            frame_backlog.push_back('{d, fe, 1'b0});
    endtask

    // One byte of the padded image, preceded by a descriptor when it opens a
    // block and followed by the trailer when it closes the image.
    task automatic queue_payload(input logic [7:0] b);
        logic                    last_blk;
        logic [15:0]             dlen;
        logic [31:0]             w0;
        logic [15:0]             hsum;
        logic [DESC_BYTES*8-1:0] desc;
        if (pad_left == 0)
            return;
        if (blk_ofs == 0)
        begin
            last_blk = (pad_left <= BLOCK_PAYLOAD);
            dlen = last_blk ? 16'(pad_left + TRAILER_BYTES) : 16'(BLOCK_PAYLOAD);
            w0 = '0;
            w0[1:0] = type_reg;
            w0[DESC_LAST_BIT] = last_blk;
            w0[DESC_FIRST_BIT] = first_pend;
            w0[DESC_SEL_BIT] = sel_reg;
            w0[DESC_SEQ_BIT] = 1'b1;
            // Halfwords other than 0, 1 and 4 are zero, so they drop out of the XOR.
            hsum = w0[15:0] ^ w0[31:16] ^ dlen;
            desc = {hsum, 64'h0, dlen, 32'h0, w0};
            for (int i = 0; i < DESC_BYTES; i++)
                queue_byte(desc[8*i +: 8], 1'b0);
            first_pend = 1'b0;
        end
        pad_left--;
        blk_ofs++;
        if (pad_left == 0)
        begin
            queue_byte(b, 1'b0);
            for (int i = 0; i < TRAILER_BYTES; i++)
                queue_byte(i < 2 ? csum[8*i +: 8] : 8'h00, i == TRAILER_BYTES - 1);
            blk_ofs = 0;
        end
        else if (blk_ofs >= BLOCK_PAYLOAD)
        begin
            queue_byte(b, 1'b1);
            blk_ofs = 0;
        end
        else
        begin
            queue_byte(b, 1'b0);
        end
    endtask

    // Advances the model by one accepted image byte and queues the beats
    // that this byte releases.
    task automatic frame_image_byte(input logic [7:0] b);
        int          img_len;
        int          padded;
        int          run;
        frame_beat_t beat;
        if (bytes_left == 0)
        begin
            // A new image samples the length; zero counts as one byte.
            img_len = (len_reg == 0) ? 1 : int'(len_reg);
            padded = (img_len + 3) & ~3;
            if (padded % BLOCK_PAYLOAD == 0)
                padded += 4;
            bytes_left = img_len;
            pad_left = padded;
            blk_ofs = 0;
            first_pend = 1'b1;
            csum = '0;
            parity = 1'b0;
        end
        csum ^= parity ? {b, 8'h00} : {8'h00, b};
        parity ^= 1'b1;
        bytes_left--;
        queue_payload(b);
        if (bytes_left == 0)
        begin
            // The last image byte also carries the zero padding and the tail.
            while (pad_left > 0)
                queue_payload(8'h00);
            blk_ofs = 0;
            first_pend = 1'b1;
        end
        run = (frame_backlog.size() < MAX_RUN) ? frame_backlog.size() : MAX_RUN;
        for (int k = 0; k < run; k++)
        begin
            beat = frame_backlog.pop_front();
            beat.rend = (k == run - 1);
            frame_expect.push_back(beat);
        end
        last_run_len = run;
    endtask

    task automatic log_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus side. An image byte is offered with valid held high and the
    // payload stable until the block takes it. The sender works in bursts:
    // after most bursts it drops valid for a random gap, and now and then a
    // long burst runs with no gaps at all.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        int pick;
        in_valid <= 1'b1;
        image_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        frame_image_byte(b);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                gap = 0;
            else if (pick < 8)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(5, 25);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Register writes happen only with the block idle: the input is
    // withdrawn, every expected beat has to arrive, and then the tail of
    // any image gets time to finish going into the queue.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (frame_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The enable is high for a single cycle, and the task returns only after
    // the enable has been sampled low, so back-to-back writes never raise
    // and lower the enable in the same step.
    task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IMAGE_LENGTH: len_reg = val;
            CFG_IMAGE_SELECT: sel_reg = val[0];
            CFG_FRAME_TYPE:   type_reg = val[1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side. Ready follows an eight-bit mask that rotates every
    // cycle and is redrawn whenever the low six bits of ready_tick are zero.
    // A quarter of the masks are all ones, so some stretches see no stalls;
    // every mask keeps at least one ready cycle in eight.
    // ------------------------------------------------------------------
    logic [7:0] ready_tick = '0;
    logic [7:0] ready_mask = 8'hFF;

    always @(posedge clk)
    begin
        ready_tick <= ready_tick + 8'd1;
        if (ready_tick[5:0] == 6'd0)
        begin
            if ($urandom_range(0, 3) == 0)
                ready_mask <= 8'hFF;
            else
                ready_mask <= 8'($urandom) | 8'h01;
        end
        out_ready <= ready_mask[ready_tick[2:0]];
    end

    // Every output beat taken is compared with the oldest expected beat.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_expect.size() == 0)
            begin
                log_mismatch($sformatf("unexpected beat byte %h end %b run %b",
                                       frame_byte, frame_end, run_end));
            end
            else
            begin
                if ({frame_byte, frame_end, run_end} !== frame_expect[0])
                    log_mismatch($sformatf(
                        "expected byte %h end %b run %b, got byte %h end %b run %b",
                        frame_expect[0].data, frame_expect[0].fend, frame_expect[0].rend,
                        frame_byte, frame_end, run_end));
                void'(frame_expect.pop_front());
            end
        end
    end

    // A hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    plan_row_t dir_plan [DIR_ROWS];

    initial
    begin
        int          random_sent;
        int          img_len;
        plan_row_t   row;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        image_byte = '0;
        random_sent = 0;

        // Directed images. The first byte runs on the reset settings: a
        // one-byte image, so its run is a full descriptor, the byte, three
        // padding bytes and the trailer. Then come a zero length (taken as
        // one), an image with two padding bytes, one with three, one that
        // needs no padding and one with a single padding byte, with both
        // extremes of every byte bit and of the select and type registers.
        dir_plan = '{
            '{ROW_BYTE, '0,               21'h0000FF, 1'b1, 6'd28, 16'h00FF},
            '{ROW_CFG,  CFG_FRAME_TYPE,   21'd3,      1'b0, 6'd0,  16'h0000},
            '{ROW_CFG,  CFG_IMAGE_SELECT, 21'd1,      1'b0, 6'd0,  16'h0000},
            '{ROW_CFG,  CFG_IMAGE_LENGTH, 21'd0,      1'b0, 6'd0,  16'h0000},
            '{ROW_BYTE, '0,               21'h000000, 1'b1, 6'd28, 16'h0000},
            '{ROW_CFG,  CFG_FRAME_TYPE,   21'd1,      1'b0, 6'd0,  16'h0000},
            '{ROW_CFG,  CFG_IMAGE_SELECT, 21'd0,      1'b0, 6'd0,  16'h0000},
            '{ROW_CFG,  CFG_IMAGE_LENGTH, 21'd2,      1'b0, 6'd0,  16'h0000},
            '{ROW_BYTE, '0,               21'h000012, 1'b1, 6'd21, 16'h0012},
            '{ROW_BYTE, '0,               21'h000034, 1'b1, 6'd7,  16'h3412},
            '{ROW_CFG,  CFG_IMAGE_LENGTH, 21'd5,      1'b0, 6'd0,  16'h0000},
            '{ROW_CFG,  CFG_FRAME_TYPE,   21'd2,      1'b0, 6'd0,  16'h0000},
            '{ROW_BYTE, '0,               21'h000001, 1'b1, 6'd21, 16'h0001},
            '{ROW_BYTE, '0,               21'h000002, 1'b0, 6'd0,  16'h0000},
            '{ROW_BYTE, '0,               21'h000003, 1'b0, 6'd0,  16'h0000},
            '{ROW_BYTE, '0,               21'h000004, 1'b0, 6'd0,  16'h0000},
            '{ROW_BYTE, '0,               21'h000005, 1'b1, 6'd8,  16'h0607},
            '{ROW_CFG,  CFG_IMAGE_LENGTH, 21'd4,      1'b0, 6'd0,  16'h0000},
            '{ROW_CFG,  CFG_IMAGE_SELECT, 21'd1,      1'b0, 6'd0,  16'h0000},
            '{ROW_BYTE, '0,               21'h0000AA, 1'b1, 6'd21, 16'h00AA},
            '{ROW_BYTE, '0,               21'h000055, 1'b0, 6'd0,  16'h0000},
            '{ROW_BYTE, '0,               21'h0000FF, 1'b0, 6'd0,  16'h0000},
            '{ROW_BYTE, '0,               21'h000000, 1'b1, 6'd5,  16'h5555},
            '{ROW_CFG,  CFG_IMAGE_LENGTH, 21'd3,      1'b0, 6'd0,  16'h0000},
            '{ROW_CFG,  CFG_FRAME_TYPE,   21'd0,      1'b0, 6'd0,  16'h0000},
            '{ROW_BYTE, '0,               21'h000080, 1'b1, 6'd21, 16'h0080},
            '{ROW_BYTE, '0,               21'h00007F, 1'b0, 6'd0,  16'h0000},
            '{ROW_BYTE, '0,               21'h000001, 1'b1, 6'd6,  16'h7F81}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = dir_plan[r];
            if (row.kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(row.idx, row.val);
            end
            else
            begin
                send_byte(row.val[7:0]);
                // Pinned rows hold the run length and checksum worked out
                // by hand; a model that disagrees is logged as a mismatch.
                if (row.pinned && (last_run_len != int'(row.run_len) || csum !== row.sum))
                    log_mismatch($sformatf(
                        "table row %0d: expected run %0d sum %h, got run %0d sum %h",
                        r, row.run_len, row.sum, last_run_len, csum));
            end
        end

        // Random images, each with a fresh length and now and then a new
        // select or type. Most are short, so many images start and end and the
        // padding, trailer and first-block paths are hit often.
        while (random_sent < 350)
        begin
            wait_idle();
            if ($urandom_range(0, 3) == 0)
                img_len = $urandom_range(17, 60);
            else
                img_len = $urandom_range(1, 16);
            write_reg(CFG_IMAGE_LENGTH, 21'(img_len));
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_IMAGE_SELECT, 21'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_FRAME_TYPE, 21'($urandom_range(0, 3)));
            repeat (img_len)
            begin
                send_byte(8'($urandom_range(0, 255)));
                random_sent++;
            end
        end

        // An image length with only the length register's top bit set: only its
        // opening bytes are sent, which shows a full-size, not-last descriptor.
        wait_idle();
        write_reg(CFG_IMAGE_LENGTH, 21'd1048576);
        write_reg(CFG_IMAGE_SELECT, 21'd1);
        write_reg(CFG_FRAME_TYPE, 21'd3);
        repeat (40) send_byte(8'($urandom_range(0, 255)));

        // Drain every expected beat, then watch a while for stray beats.
        in_valid <= 1'b0;
        while (frame_expect.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
rtl/core/fbf_pkg.sv
rtl/core/fbf_ram.sv
rtl/core/fbf_framer.sv
rtl/core/firmware_block_framer_top.sv
rtl/core/fbf_checker.sv
tb/firmware_block_framer_top_tb.sv
